// ===== hdl/multilevel_timing_wheel_unit_macros.svh =====
// Assertion macros used by the bound checker in hdl/mtw_checker.sv.
`ifndef MULTILEVEL_TIMING_WHEEL_UNIT_MACROS_SVH
`define MULTILEVEL_TIMING_WHEEL_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MTW_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mtw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mtw_pkg;

  // Command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_STARTED = 3'd0;
  localparam logic [2:0] KIND_FAILED  = 3'd1;
  localparam logic [2:0] KIND_FIRED   = 3'd2;
  localparam logic [2:0] KIND_DONE    = 3'd3;
  localparam logic [2:0] KIND_STOPPED = 3'd4;

  // x / 10 == (x * DIV10_MUL) >> DIV10_SHIFT for every 16-bit x
  localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
  localparam int          DIV10_SHIFT = 19;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] now_ms;
    logic [2:0]  level;
    logic [7:0]  period;
    logic [15:0] tag;
    logic [4:0]  handle;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  entry;
    logic [15:0] fired_tag;
    logic        last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       tk_begin;
    logic       tk_scan;
    logic       tk_next;
    logic       al_init;
    logic       al_scan;
    logic       stop_do;
    logic       emit;
    logic [2:0] emit_kind;
  } mtw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] command;
    logic       lvl_bad;
    logic       tk_stop;
    logic       scan_done;
    logic       al_free;
    logic       al_full;
  } mtw_stat_t;

endpackage
`default_nettype wire

// ===== hdl/mtw_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mtw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/mtw_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mtw_ctrl
  import mtw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire mtw_stat_t stat,
  output mtw_cmd_t       cmd
);
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DISP  = 3'd1;
  localparam logic [2:0] ST_TCMP  = 3'd2;
  localparam logic [2:0] ST_TSCAN = 3'd3;
  localparam logic [2:0] ST_TNEXT = 3'd4;
  localparam logic [2:0] ST_AINIT = 3'd5;
  localparam logic [2:0] ST_ASCAN = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign busy = (state_r != ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        unique case (stat.command)
          CMD_TICK:  state_nxt = ST_TCMP;
          CMD_START: begin
            if (stat.lvl_bad) begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = KIND_FAILED;
              state_nxt     = ST_IDLE;
            end else begin
              state_nxt = ST_AINIT;
            end
          end
          CMD_STOP: begin
            cmd.stop_do   = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_STOPPED;
            state_nxt     = ST_IDLE;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_TCMP: begin
        if (stat.tk_stop) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_DONE;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.tk_begin = 1'b1;
          state_nxt    = ST_TSCAN;
        end
      end
      ST_TSCAN: begin
        cmd.tk_scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = ST_TNEXT;
        end
      end
      ST_TNEXT: begin
        cmd.tk_next = 1'b1;
        state_nxt   = ST_TCMP;
      end
      ST_AINIT: begin
        cmd.al_init = 1'b1;
        state_nxt   = ST_ASCAN;
      end
      ST_ASCAN: begin
        cmd.al_scan = 1'b1;
        if (stat.al_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_STARTED;
          state_nxt     = ST_IDLE;
        end else if (stat.al_full) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_FAILED;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/mtw_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mtw_dp
  import mtw_pkg::*;
#(
  parameter int POOL   = 32,
  parameter int SLOTS  = 10,
  parameter int LEVELS = 5
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_item,
  input  wire mtw_cmd_t  cmd,
  output mtw_stat_t      stat,
  output logic           out_valid,
  output out_item_t      out_item
);
  localparam int IW    = (POOL > 1) ? $clog2(POOL) : 1;
  localparam int SW    = $clog2(SLOTS);
  localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int LCW   = $clog2(LEVELS + 1);
  localparam int WW    = 3 + 2 * SW + 16;
  localparam int RECIP = (65536 + SLOTS - 1) / SLOTS;
  // word layout: level | step | slot | tag
  localparam int TAG_LO  = 0;
  localparam int SLOT_LO = 16;
  localparam int STEP_LO = 16 + SW;
  localparam int LVL_LO  = 16 + 2 * SW;

  in_item_t        in_r;
  logic [POOL-1:0] used_r, enabled_r;
  logic [SW-1:0]   pos_r [LEVELS];
  logic [15:0]     lastc_r [LEVELS];
  logic [IW-1:0]   alloc_r;
  logic [15:0]     count_r;
  logic [31:0]     prod_r;
  logic [LCW-1:0]  lv_r;
  logic [SW-1:0]   cur_r, nxt_r;
  logic [IW:0]     sc_r;
  logic            pv_r;
  logic [IW-1:0]   pi_r;
  logic [IW-1:0]   j_r;
  logic [IW:0]     cnt_r;
  logic [7:0]      q_r;
  logic            out_valid_r;
  out_item_t       out_r;

  logic [LW-1:0]   lvi, lidx;
  logic            lv_end;
  logic [SW-1:0]   pnext;
  logic [WW-1:0]   rd_word, wr_word;
  logic [SW-1:0]   rd_slot, rd_step, new_slot, st_step, st_slot;
  logic [SW:0]     slot_sum, st_sum;
  logic            hit, fire;
  logic [24:0]     pmul;
  logic [7:0]      prem;
  logic [IW-1:0]   hidx, waddr;
  logic            we;

  assign lvi    = lv_r[LW-1:0];
  assign lidx   = LW'(in_r.level);
  assign lv_end = (32'(lv_r) >= LEVELS);
  assign hidx   = IW'(in_r.handle);

  // wheel advance for the level being served
  assign pnext = (32'(pos_r[lvi]) == SLOTS - 1) ? '0 : pos_r[lvi] + 1'b1;

  // entry fields from the pool memory
  assign rd_slot = rd_word[SLOT_LO +: SW];
  assign rd_step = rd_word[STEP_LO +: SW];
  assign hit = pv_r && used_r[pi_r] && (rd_word[LVL_LO +: 3] == 3'(lv_r))
               && (rd_slot == cur_r);
  assign fire = cmd.tk_scan && hit && enabled_r[pi_r];

  // reschedule: (nxt + step) mod SLOTS, both below SLOTS
  assign slot_sum = {1'b0, nxt_r} + {1'b0, rd_step};
  assign new_slot = (32'(slot_sum) >= SLOTS) ? SW'(32'(slot_sum) - SLOTS) : slot_sum[SW-1:0];

  // start: step = period mod SLOTS via reciprocal quotient
  assign pmul    = 25'(in_r.period) * 25'(RECIP);
  assign prem    = in_r.period - 8'(q_r * 8'(SLOTS));
  assign st_step = prem[SW-1:0];
  assign st_sum  = {1'b0, pos_r[lidx]} + {1'b0, st_step};
  assign st_slot = (32'(st_sum) >= SLOTS) ? SW'(32'(st_sum) - SLOTS) : st_sum[SW-1:0];

  // status
  assign stat.command   = in_r.command;
  assign stat.lvl_bad   = (32'(in_r.level) >= LEVELS);
  assign stat.tk_stop   = lv_end ? 1'b1 : (lastc_r[lvi] == count_r);
  assign stat.scan_done = (32'(sc_r) == POOL) && !pv_r;
  assign stat.al_full   = (32'(cnt_r) == POOL);
  assign stat.al_free   = !stat.al_full && !used_r[j_r];

  // memory write: reschedule on fire, fresh entry on start
  always_comb begin
    we      = 1'b0;
    waddr   = pi_r;
    wr_word = rd_word;
    if (fire) begin
      we      = 1'b1;
      wr_word[SLOT_LO +: SW] = new_slot;
    end else if (cmd.al_scan && stat.al_free) begin
      we      = 1'b1;
      waddr   = j_r;
      wr_word = {in_r.level, st_step, st_slot, in_r.tag};
    end
  end

  mtw_ram #(.WIDTH(WW), .DEPTH(POOL)) u_pool (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_word),
    .raddr (sc_r[IW-1:0]),
    .rdata (rd_word)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      enabled_r   <= '0;
      alloc_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        pos_r[i]   <= '0;
        lastc_r[i] <= '0;
      end
    end else begin
      out_valid_r <= cmd.emit || fire;
      if (cmd.tk_begin) begin
        lastc_r[lvi] <= count_r;
        pos_r[lvi]   <= pnext;
      end
      if (cmd.tk_scan && hit && !enabled_r[pi_r]) begin
        used_r[pi_r] <= 1'b0;
      end
      if (cmd.al_scan && stat.al_free) begin
        used_r[j_r]    <= 1'b1;
        enabled_r[j_r] <= 1'b1;
        alloc_r        <= j_r;
      end
      if (cmd.stop_do && (32'(in_r.handle) < POOL)) begin
        enabled_r[hidx] <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r    <= in_item;
      count_r <= in_item.now_ms;
      lv_r    <= '0;
    end
    if (cmd.tk_begin) begin
      cur_r <= pos_r[lvi];
      nxt_r <= pnext;
      sc_r  <= '0;
      pv_r  <= 1'b0;
    end
    if (cmd.tk_scan) begin
      prod_r <= count_r * DIV10_MUL;
      if (32'(sc_r) != POOL) begin
        sc_r <= sc_r + 1'b1;
        pv_r <= 1'b1;
        pi_r <= sc_r[IW-1:0];
      end else begin
        pv_r <= 1'b0;
      end
    end
    if (cmd.tk_next) begin
      count_r <= 16'(prod_r[31:DIV10_SHIFT]);
      lv_r    <= lv_r + 1'b1;
    end
    if (cmd.al_init) begin
      j_r   <= alloc_r;
      cnt_r <= '0;
      q_r   <= 8'(pmul[24:16]);
    end
    if (cmd.al_scan && !stat.al_free && !stat.al_full) begin
      j_r   <= (32'(j_r) == POOL - 1) ? '0 : j_r + 1'b1;
      cnt_r <= cnt_r + 1'b1;
    end
    // result register
    if (fire) begin
      out_r <= '{kind: KIND_FIRED, entry: 5'(pi_r), fired_tag: rd_word[TAG_LO +: 16],
                 last: 1'b0};
    end else if (cmd.emit) begin
      out_r <= '{kind: cmd.emit_kind,
                 entry: (cmd.emit_kind == KIND_STARTED) ? 5'(j_r) : 5'd0,
                 fired_tag: 16'd0, last: 1'b1};
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;
endmodule
`default_nettype wire

// ===== hdl/multilevel_timing_wheel_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   ports                      handshake
// input     in_item                    accepted when start && !busy
// result    out_valid, out_item        one-cycle strobe, always taken
//
// Start checks one pool entry per cycle from the last allocation. Tick reads
// one entry per cycle from the pool RAM for each changed level.
// Reset is synchronous, active low; it frees the pool and zeroes the wheels.
// Fired results stream out during the scan; the receiver cannot stall them.
module multilevel_timing_wheel_unit
  import mtw_pkg::*;
#(
  parameter int POOL   = 32,
  parameter int SLOTS  = 10,
  parameter int LEVELS = 5
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_item,
  output logic          out_valid,
  output out_item_t     out_item
);
  mtw_cmd_t  cmd;
  mtw_stat_t stat;

  mtw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  mtw_dp #(.POOL(POOL), .SLOTS(SLOTS), .LEVELS(LEVELS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );
endmodule
`default_nettype wire

// ===== hdl/mtw_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "multilevel_timing_wheel_unit_macros.svh"
module mtw_checker
  import mtw_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      out_valid,
  input wire out_item_t out_item
);
  // an accepted item keeps the block busy
  `MTW_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  // only fired results may be non-final
  `MTW_ASSERT_IMPLY(a_last_kind, out_valid && out_item.kind != KIND_FIRED, out_item.last, "non-fire result without last")
  // nothing follows the final result directly
  `MTW_ASSERT_NEXT(a_after_last, out_valid && out_item.last, !out_valid, "result right after last")
  // tag only on fired results
  `MTW_ASSERT_IMPLY(a_tag_zero, out_valid && out_item.kind != KIND_FIRED, out_item.fired_tag == 16'd0, "tag on non-fire result")
endmodule

bind multilevel_timing_wheel_unit mtw_checker u_mtw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
`default_nettype wire

// ===== tb/sv/mtw_checker.sv =====
`timescale 1ns / 1ps
module tb_mtw_checker
  import mtw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending
);

  localparam int POOL   = 32;
  localparam int SLOTS  = 10;
  localparam int LEVELS = 5;

  // wheel state mirror
  bit          used_q    [POOL];
  bit          enabled_q [POOL];
  logic [2:0]  lvl_q     [POOL];
  logic [3:0]  slot_q    [POOL];
  logic [3:0]  step_q    [POOL];
  logic [15:0] tag_q     [POOL];
  logic [3:0]  wheel_pos [LEVELS];
  logic [15:0] level_cnt [LEVELS];
  logic [4:0]  alloc_ptr;

  out_item_t   result_fifo[$];

  task automatic report_mismatch(input string what, input out_item_t got, input out_item_t exp);
    $display("%0t MISMATCH %s: got kind=%0d entry=%0d tag=%h last=%0d exp kind=%0d entry=%0d tag=%h last=%0d",
             $time, what, got.kind, got.entry, got.fired_tag, got.last,
             exp.kind, exp.entry, exp.fired_tag, exp.last);
    fail_count++;
  endtask

  function automatic out_item_t mk(logic [2:0] k, logic [4:0] e, logic [15:0] t, logic l);
    out_item_t r;
    r.kind = k; r.entry = e; r.fired_tag = t; r.last = l;
    return r;
  endfunction

  // advance one level's wheel, queueing fired items
  task automatic serve_level(input int lv);
    bit hit [POOL];
    int cur;
    int nxt;
    cur = wheel_pos[lv];
    nxt = (cur + 1) % SLOTS;
    for (int i = 0; i < POOL; i++)
      hit[i] = used_q[i] && lvl_q[i] == lv && slot_q[i] == cur;
    wheel_pos[lv] = 4'(nxt);
    for (int i = 0; i < POOL; i++) begin
      if (hit[i]) begin
        if (!enabled_q[i]) begin
          used_q[i] = 0;
        end else begin
          result_fifo.push_back(mk(KIND_FIRED, 5'(i), tag_q[i], 1'b0));
          slot_q[i] = 4'((nxt + step_q[i]) % SLOTS);
        end
      end
    end
  endtask

  task automatic predict_item(input in_item_t it);
    int cnt;
    int j;
    bit done;
    case (it.command)
      CMD_TICK: begin
        cnt = it.now_ms;
        for (int lv = 0; lv < LEVELS; lv++) begin
          if (level_cnt[lv] == cnt) break;
          level_cnt[lv] = 16'(cnt);
          serve_level(lv);
          cnt = cnt / 10;
        end
        result_fifo.push_back(mk(KIND_DONE, 5'd0, 16'd0, 1'b1));
      end
      CMD_START: begin
        done = 0;
        if (it.level < LEVELS) begin
          for (int i = 0; i < POOL && !done; i++) begin
            j = (alloc_ptr + i) % POOL;
            if (!used_q[j]) begin
              alloc_ptr    = 5'(j);
              used_q[j]    = 1;
              enabled_q[j] = 1;
              lvl_q[j]     = it.level;
              step_q[j]    = 4'(it.period % SLOTS);
              tag_q[j]     = it.tag;
              slot_q[j]    = 4'((wheel_pos[it.level] + it.period % SLOTS) % SLOTS);
              result_fifo.push_back(mk(KIND_STARTED, 5'(j), 16'd0, 1'b1));
              done = 1;
            end
          end
        end
        if (!done) result_fifo.push_back(mk(KIND_FAILED, 5'd0, 16'd0, 1'b1));
      end
      CMD_STOP: begin
        enabled_q[it.handle] = 0;
        result_fifo.push_back(mk(KIND_STOPPED, 5'd0, 16'd0, 1'b1));
      end
      default: ;
    endcase
  endtask

  // watch both channels
  always @(posedge clk) begin
    out_item_t exp;
    if (!rst_n) begin
      for (int i = 0; i < POOL; i++) begin
        used_q[i] = 0; enabled_q[i] = 0;
      end
      for (int i = 0; i < LEVELS; i++) begin
        wheel_pos[i] = 0; level_cnt[i] = 0;
      end
      alloc_ptr = 0;
      result_fifo.delete();
    end else begin
      if (out_valid) begin
        if (result_fifo.size() == 0) begin
          report_mismatch("unexpected item", out_item, '0);
        end else begin
          exp = result_fifo.pop_front();
          if (out_item !== exp) report_mismatch("field", out_item, exp);
        end
      end
      if (start && !busy) predict_item(in_item);
    end
    pending = result_fifo.size();
  end

  initial begin
    fail_count = 0;
    pending    = 0;
  end

endmodule

// ===== tb/sv/tb_multilevel_timing_wheel_unit.sv =====
`timescale 1ns / 1ps
module tb_multilevel_timing_wheel_unit;
  import mtw_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  // command code with no meaning
  localparam logic [1:0] CMD_UNDEF = 2'd3;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      start = 0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;
  int        fail_count;
  int        pending;
  int        idle_cycles = 0;
  logic [15:0] now_q = 0;

  always #1 clk = ~clk;

  multilevel_timing_wheel_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  tb_mtw_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .fail_count(fail_count), .pending(pending)
  );

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("multilevel_timing_wheel_unit verification failed");
        $finish;
      end
    end
  end

  // hold one item until accepted, after a random gap
  task automatic send_item(input in_item_t it);
    int gap;
    gap = $urandom_range(0, 18);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
  endtask

  function automatic in_item_t noise();
    in_item_t it;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  task automatic send_tick(input logic [15:0] ms);
    in_item_t it;
    it = noise();
    it.command = CMD_TICK;
    it.now_ms  = ms;
    send_item(it);
  endtask

  task automatic send_start(input logic [2:0] lv, input logic [7:0] per, input logic [15:0] tg);
    in_item_t it;
    it = noise();
    it.command = CMD_START; it.level = lv; it.period = per; it.tag = tg;
    send_item(it);
  endtask

  task automatic send_stop(input logic [4:0] h);
    in_item_t it;
    it = noise();
    it.command = CMD_STOP; it.handle = h;
    send_item(it);
  endtask

  initial begin
    in_item_t it;
    int r;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, bad level, stop of free entry, undefined command
    send_start(3'd0, 8'd0, 16'h0000);
    send_start(3'd4, 8'd255, 16'hFFFF);
    send_start(3'd5, 8'd3, 16'h1234);
    send_start(3'd7, 8'd3, 16'h1234);
    send_start(3'd0, 8'd9, 16'hA5A5);
    send_stop(5'd31);
    send_stop(5'd0);
    it = noise(); it.command = CMD_UNDEF; send_item(it);
    send_tick(16'd1);
    send_tick(16'd1);
    send_tick(16'd10);
    send_tick(16'd65535);
    send_tick(16'd0);
    // fill the pool to reach the full case
    for (int i = 0; i < 33; i++) send_start(3'(i % 5), 8'(i), 16'(16'hF000 + i));
    for (int i = 0; i < 20; i++) begin
      now_q = now_q + 16'd1;
      send_tick(now_q);
    end
    for (int i = 0; i < 32; i += 3) send_stop(5'(i));

    // random: mostly ordered ticks with starts and stops
    for (int n = 0; n < 155; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        now_q = ($urandom_range(0, 19) == 0) ? 16'($urandom)
                                             : 16'(now_q + $urandom_range(1, 12));
        send_tick(now_q);
      end else if (r < 75) begin
        send_start(($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4)),
                   8'($urandom), 16'($urandom));
      end else if (r < 95) begin
        send_stop(5'($urandom));
      end else begin
        send_item(noise());
      end
    end
    start <= 1'b0;

    // drain
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("multilevel_timing_wheel_unit verification clean");
    else
      $display("multilevel_timing_wheel_unit verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/mtw_pkg.sv
hdl/mtw_ram.sv
hdl/mtw_ctrl.sv
hdl/mtw_dp.sv
hdl/multilevel_timing_wheel_unit.sv
hdl/mtw_checker.sv
tb/sv/mtw_checker.sv
tb/sv/tb_multilevel_timing_wheel_unit.sv
